@@ hdl/swa_pkg.sv @@
// ----------------------------------------------------------------------------
// swa_pkg
// Shared types and constants for the sliding-window average core: parameter
// defaults, register widths, sequencer states and divider control bundles.
// ----------------------------------------------------------------------------
package swa_pkg;

   // Parameter defaults
   localparam int MAX_WINDOW_DEF    = 256;
   localparam int SAMPLE_BITS_DEF   = 32;
   localparam int FRACTION_BITS_DEF = 16;

   // Width of the window register and of the fill count (fixed by the ports)
   localparam int COUNT_BITS = 9;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SCALE,
      ST_DIVIDE,
      ST_DELIVER
   } swa_state_type;

   // Divider control from the sequencer
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   // Divider status back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

@@ hdl/swa_ram.sv @@
// ----------------------------------------------------------------------------
// swa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/swa_div.sv @@
// ----------------------------------------------------------------------------
// swa_div
// Radix-2 restoring divider: one quotient bit per cycle through a single
// shared subtract-and-compare unit. Unsigned dividend, nonzero divisor.
// ----------------------------------------------------------------------------
module swa_div #(
   parameter int DIV_BITS = 56
) (
   input  logic                             clock,
   input  logic                             reset,
   input  swa_pkg::div_ctrl_type            ctrl,
   input  logic [DIV_BITS-1:0]              dividend,
   input  logic [swa_pkg::COUNT_BITS-1:0]   divisor,
   output swa_pkg::div_stat_type            stat,
   output logic [DIV_BITS-1:0]              quotient
);

   localparam int CNT_BITS = $clog2(DIV_BITS + 1);
   localparam int RB       = swa_pkg::COUNT_BITS;

   logic [DIV_BITS-1:0] quo_ff, quo_in;
   logic [RB-1:0]       rem_ff, rem_in;
   logic [RB-1:0]       dsr_ff;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [RB:0]         rem_shift;
   logic [RB:0]         diff;
   logic                fits;

   // Shared subtract-and-compare step
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIV_BITS-1]};
      diff      = rem_shift - {1'b0, dsr_ff};
      fits      = (rem_shift >= {1'b0, dsr_ff});
   end

   // Next-state of the iteration registers
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_BITS'(DIV_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_BITS-2:0], fits};
         rem_in = fits ? diff[RB-1:0] : rem_shift[RB-1:0];
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (ctrl.start) begin
         dsr_ff <= divisor;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

@@ hdl/sliding_window_average_core.sv @@
// ----------------------------------------------------------------------------
// sliding_window_average_core
// Boxcar moving average: keeps the most recent samples in a ring RAM with a
// running sum and fill count, and answers each request with the fixed-point
// average of the held samples and the number held.
// ----------------------------------------------------------------------------
//  Channel  Dir  Ports                         Payload (low bit up)
//  req      in   req_tvalid/tready/tdata       sample
//  rsp      out  rsp_tvalid/tready/tdata       average, samples_held, zero pad
//  csr      in   csr_wr_en/csr_wr_data         window_length
//
//  A request is accepted only in the idle state, so the next sample waits until
//  the radix-2 divider, one quotient bit per cycle, has finished the current
//  one and its result has moved to the output register.
//  Reset clears the sum, fill count and write position and loads the window
//  register with the ring depth; the ring RAM is not cleared, since an entry
//  is read only after it is written.
//  A finished response waits in the output register; the next request is taken
//  meanwhile and the core holds before delivery until that register is free.
// ----------------------------------------------------------------------------
module sliding_window_average_core #(
   parameter int MAX_WINDOW    = swa_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS   = swa_pkg::SAMPLE_BITS_DEF,
   parameter int FRACTION_BITS = swa_pkg::FRACTION_BITS_DEF,
   parameter int REQ_BITS      = ((SAMPLE_BITS + 7) / 8) * 8,
   parameter int RSP_BITS      =
      ((SAMPLE_BITS + FRACTION_BITS + swa_pkg::COUNT_BITS + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [REQ_BITS-1:0]            req_tdata,   // sample
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [RSP_BITS-1:0]            rsp_tdata,   // average, samples_held
   // configuration
   input  logic                           csr_wr_en,
   input  logic [swa_pkg::COUNT_BITS-1:0] csr_wr_data  // window_length
);

   localparam int CB        = swa_pkg::COUNT_BITS;
   localparam int PTR_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SUM_BITS  = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int DIV_BITS  = SUM_BITS + FRACTION_BITS;
   localparam int AVG_BITS  = SAMPLE_BITS + FRACTION_BITS;
   localparam logic [CB-1:0] MAX_W = CB'(MAX_WINDOW);

   swa_pkg::swa_state_type state_ff, state_in;

   logic [CB-1:0]              window_ff;
   logic [CB-1:0]              count_ff;
   logic [PTR_BITS-1:0]        pos_ff;
   logic signed [SUM_BITS-1:0] sum_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                       neg_ff;
   logic                       rsp_valid_ff;
   logic [RSP_BITS-1:0]        rsp_data_ff;

   logic [CB-1:0]              win;
   logic [PTR_BITS-1:0]        pos_eff;
   logic [CB-1:0]              pos_next;
   logic                       full;
   logic signed [SUM_BITS-1:0] sum_in;
   logic [SUM_BITS-1:0]        mag;
   logic [DIV_BITS-1:0]        dividend;
   logic [DIV_BITS-1:0]        quotient;
   logic [DIV_BITS-1:0]        q_signed;
   logic [SAMPLE_BITS-1:0]     ram_rdata;

   logic                       accept;
   logic                       do_update;
   logic                       load_rsp;
   swa_pkg::div_ctrl_type      div_ctrl;
   swa_pkg::div_stat_type      div_stat;

   // Effective window: zero means one, above the ring depth saturates
   always_comb begin
      priority if (window_ff == '0) begin
         win = CB'(1);
      end else if (window_ff > MAX_W) begin
         win = MAX_W;
      end else begin
         win = window_ff;
      end
   end

   // Wrap the write position into the window, then advance it
   always_comb begin
      pos_eff  = (CB'(pos_ff) >= win) ? '0 : pos_ff;
      pos_next = CB'(pos_ff) + CB'(1);
      if (pos_next >= win) begin
         pos_next = '0;
      end
   end

   // Running sum update: drop the oldest sample once the window is full
   always_comb begin
      full   = (count_ff >= win);
      sum_in = sum_ff + SUM_BITS'(sample_ff);
      if (full) begin
         sum_in = sum_in - SUM_BITS'($signed(ram_rdata));
      end
   end

   // Magnitude of the sum, scaled to fixed point; the quotient gets the sign back
   always_comb begin
      mag      = sum_ff[SUM_BITS-1] ? (~sum_ff + SUM_BITS'(1)) : sum_ff;
      dividend = DIV_BITS'(mag) << FRACTION_BITS;
      q_signed = neg_ff ? (~quotient + DIV_BITS'(1)) : quotient;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         swa_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = swa_pkg::ST_UPDATE;
            end
         end
         swa_pkg::ST_UPDATE:  state_in = swa_pkg::ST_SCALE;
         swa_pkg::ST_SCALE:   state_in = swa_pkg::ST_DIVIDE;
         swa_pkg::ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = swa_pkg::ST_DELIVER;
            end
         end
         swa_pkg::ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = swa_pkg::ST_IDLE;
            end
         end
         default: state_in = swa_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready     = 1'b0;
      do_update      = 1'b0;
      div_ctrl.start = 1'b0;
      load_rsp       = 1'b0;
      unique case (state_ff)
         swa_pkg::ST_IDLE:    req_tready     = 1'b1;
         swa_pkg::ST_UPDATE:  do_update      = 1'b1;
         swa_pkg::ST_SCALE:   div_ctrl.start = 1'b1;
         swa_pkg::ST_DIVIDE:  ;
         swa_pkg::ST_DELIVER: load_rsp       = !rsp_valid_ff || rsp_tready;
         default:             ;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swa_pkg::ST_IDLE;
         window_ff    <= MAX_W;
         count_ff     <= '0;
         pos_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
            count_ff  <= '0;
            pos_ff    <= '0;
            sum_ff    <= '0;
         end else if (accept) begin
            pos_ff <= pos_eff;
         end else if (do_update) begin
            sum_ff <= sum_in;
            pos_ff <= PTR_BITS'(pos_next);
            if (!full) begin
               count_ff <= count_ff + CB'(1);
            end
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_tdata[SAMPLE_BITS-1:0];
      end
      if (div_ctrl.start) begin
         neg_ff <= sum_ff[SUM_BITS-1];
      end
      if (load_rsp) begin
         rsp_data_ff <= RSP_BITS'({count_ff, q_signed[AVG_BITS-1:0]});
      end
   end

   // Sample ring: read the oldest slot at accept, write the new sample on update
   swa_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW),
      .ADDR_BITS (PTR_BITS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (do_update),
      .wr_addr (pos_ff),
      .wr_data (sample_ff),
      .rd_addr (pos_eff),
      .rd_data (ram_rdata)
   );

   // Radix-2 divider
   swa_div #(
      .DIV_BITS (DIV_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (dividend),
      .divisor  (count_ff),
      .stat     (div_stat),
      .quotient (quotient)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ hdl/swa_checker.sv @@
// ----------------------------------------------------------------------------
// swa_checker
// Port-level checks for the sliding-window average core, bound to the top.
// ----------------------------------------------------------------------------
module swa_checker #(
   parameter int SAMPLE_BITS   = swa_pkg::SAMPLE_BITS_DEF,
   parameter int FRACTION_BITS = swa_pkg::FRACTION_BITS_DEF,
   parameter int REQ_BITS      = ((SAMPLE_BITS + 7) / 8) * 8,
   parameter int RSP_BITS      =
      ((SAMPLE_BITS + FRACTION_BITS + swa_pkg::COUNT_BITS + 7) / 8) * 8
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [REQ_BITS-1:0]            req_tdata,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [RSP_BITS-1:0]            rsp_tdata,
   input logic                           csr_wr_en,
   input logic [swa_pkg::COUNT_BITS-1:0] csr_wr_data
);

   localparam int AVG_BITS = SAMPLE_BITS + FRACTION_BITS;
   localparam int CB       = swa_pkg::COUNT_BITS;

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed or dropped");

   // One request at a time: drop ready right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // Every response holds at least one sample
   a_held_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[AVG_BITS+CB-1:AVG_BITS] != '0)
      else $error("response with empty window");

   // Come out of reset idle and empty
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("core not idle after reset");

endmodule

bind sliding_window_average_core swa_checker #(
   .SAMPLE_BITS   (SAMPLE_BITS),
   .FRACTION_BITS (FRACTION_BITS),
   .REQ_BITS      (REQ_BITS),
   .RSP_BITS      (RSP_BITS)
) u_swa_checker (.*);
